FILE: design/datetime_text_parser_macros.svh
// assertion macros used by the port-level checker of the timestamp parser
// depends on nothing; each macro expands to one labelled concurrent assertion
`ifndef DATETIME_TEXT_PARSER_MACROS_SVH
`define DATETIME_TEXT_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timestamp parser check failed");

// next-cycle implication, disabled during reset
`define DTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timestamp parser check failed");

`endif

FILE: design/dtp_pkg.sv
// types and constants of the timestamp text parser
// depends on nothing; imported by the top level, both checkers and the testbench top
package dtp_pkg;

  // result kind codes
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_ERROR    = 3'd1;
  localparam logic [2:0] KIND_DATE     = 3'd2;
  localparam logic [2:0] KIND_TIME     = 3'd3;
  localparam logic [2:0] KIND_DATETIME = 3'd4;

  // component slots, in order of appearance
  localparam logic [2:0] PH_FIRST    = 3'd0;
  localparam logic [2:0] PH_SECOND   = 3'd1;
  localparam logic [2:0] PH_THIRD    = 3'd2;
  localparam logic [2:0] PH_HOUR     = 3'd3;
  localparam logic [2:0] PH_MINUTE   = 3'd4;
  localparam logic [2:0] PH_SEC      = 3'd5;
  localparam logic [2:0] PH_FRACTION = 3'd6;

  localparam int NUM_COMPONENTS = 7;

  // characters that matter
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
    logic       empty_string;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] year_value;
    logic [31:0] month_value;
    logic [31:0] day_value;
    logic [31:0] hour_value;
    logic [31:0] minute_value;
    logic [31:0] second_value;
    logic [31:0] fraction_value;
  } result_t;

endpackage

FILE: design/datetime_text_parser.sv
// top level of the streaming timestamp text parser
// depends on dtp_pkg for the request and result types and the codes
//
// Takes one character per cycle, except while a closing request waits for a free
// result register, and gives one result when a string closes (on the last
// character or on an empty-string request). A closing request passes from the
// input register into the result register. The multiply-by-ten accumulate of the
// current component (a 36-bit add and overflow check) lies between the input
// register and the parse state. An input register and a result register decouple
// the two sides, so a request is taken while a finished result waits; only a
// closing request waits for a free result register.
module datetime_text_parser
  import dtp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // input register
  logic  in_valid;
  item_t in_q;

  // parse state
  logic [2:0]  phase;
  logic        colon_mode;
  logic        separator_seen;
  logic        failed;
  logic        digit_seen;
  logic [31:0] components [NUM_COMPONENTS];

  // updated state after this character
  logic [2:0]  phase_next;
  logic        colon_mode_next;
  logic        separator_seen_next;
  logic        failed_next;
  logic        digit_seen_next;
  logic [31:0] comp_value_next;
  logic        comp_write;

  logic        closes;
  logic        fire;
  logic        is_colon;
  logic        is_dash;
  logic        is_digit;
  logic        sep_ok;
  logic [35:0] acc;
  logic [31:0] cur_comp;
  logic [31:0] comp_view [NUM_COMPONENTS];
  result_t     result_next;

  assign closes     = in_q.empty_string | in_q.last_char;
  assign fire       = in_valid & (~closes | ~result_valid | result_ready);
  assign item_ready = ~in_valid | fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
  end

  // character classes
  assign is_colon = (in_q.char_byte == CH_COLON);
  assign is_dash  = (in_q.char_byte == CH_DASH);
  assign is_digit = (in_q.char_byte >= CH_ZERO) && (in_q.char_byte <= CH_NINE);

  // separator allowed to close the current component
  always_comb begin
    unique case (phase)
      PH_FIRST:  sep_ok = is_colon | is_dash;
      PH_SECOND: sep_ok = colon_mode ? is_colon : is_dash;
      PH_THIRD:  sep_ok = ~colon_mode && (in_q.char_byte == CH_SPACE);
      PH_HOUR,
      PH_MINUTE: sep_ok = is_colon;
      PH_SEC:    sep_ok = (in_q.char_byte == CH_DOT);
      default:   sep_ok = 1'b0;
    endcase
  end

  // times ten plus digit on the current component
  assign cur_comp = components[phase];
  assign acc = {1'b0, cur_comp, 3'b000} + {3'b000, cur_comp, 1'b0}
             + {32'd0, in_q.char_byte[3:0]};

  // per-character state update
  always_comb begin
    phase_next          = phase;
    colon_mode_next     = colon_mode;
    separator_seen_next = separator_seen | is_colon | is_dash;
    failed_next         = failed;
    digit_seen_next     = digit_seen;
    comp_value_next     = acc[31:0];
    comp_write          = 1'b0;
    if (!failed) begin
      if (is_digit) begin
        if (acc[35:32] != 4'd0) begin
          failed_next = 1'b1;
        end else begin
          comp_write      = 1'b1;
          digit_seen_next = 1'b1;
        end
      end else if (!digit_seen || !sep_ok) begin
        failed_next = 1'b1;
      end else begin
        if (phase == PH_FIRST) begin
          colon_mode_next = is_colon;
        end
        phase_next      = phase + 3'd1;
        digit_seen_next = 1'b0;
      end
    end
  end

  // components as seen after this character
  always_comb begin
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      comp_view[i] = components[i];
    end
    if (comp_write) begin
      comp_view[phase] = comp_value_next;
    end
  end

  // result of a closing request
  always_comb begin
    result_next = '0;
    if (in_q.empty_string || !separator_seen_next) begin
      result_next.result_kind = KIND_NONE;
    end else if (failed_next || !digit_seen_next) begin
      result_next.result_kind = KIND_ERROR;
    end else if (phase_next == PH_THIRD) begin
      result_next.result_kind = colon_mode_next ? KIND_TIME : KIND_DATE;
    end else if (phase_next == PH_SEC || phase_next == PH_FRACTION) begin
      result_next.result_kind = KIND_DATETIME;
    end else begin
      result_next.result_kind = KIND_ERROR;
    end
    case (result_next.result_kind)
      KIND_DATE: begin
        result_next.year_value  = comp_view[PH_FIRST];
        result_next.month_value = comp_view[PH_SECOND];
        result_next.day_value   = comp_view[PH_THIRD];
      end
      KIND_TIME: begin
        result_next.hour_value   = comp_view[PH_FIRST];
        result_next.minute_value = comp_view[PH_SECOND];
        result_next.second_value = comp_view[PH_THIRD];
      end
      KIND_DATETIME: begin
        result_next.year_value     = comp_view[PH_FIRST];
        result_next.month_value    = comp_view[PH_SECOND];
        result_next.day_value      = comp_view[PH_THIRD];
        result_next.hour_value     = comp_view[PH_HOUR];
        result_next.minute_value   = comp_view[PH_MINUTE];
        result_next.second_value   = comp_view[PH_SEC];
        result_next.fraction_value =
          (phase_next == PH_FRACTION) ? comp_view[PH_FRACTION] : 32'd0;
      end
      default: begin
      end
    endcase
  end

  // parse state, cleared when a string closes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIRST;
      colon_mode     <= 1'b0;
      separator_seen <= 1'b0;
      failed         <= 1'b0;
      digit_seen     <= 1'b0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        components[i] <= 32'd0;
      end
    end else if (fire) begin
      if (closes) begin
        phase          <= PH_FIRST;
        colon_mode     <= 1'b0;
        separator_seen <= 1'b0;
        failed         <= 1'b0;
        digit_seen     <= 1'b0;
        for (int i = 0; i < NUM_COMPONENTS; i++) begin
          components[i] <= 32'd0;
        end
      end else begin
        phase          <= phase_next;
        colon_mode     <= colon_mode_next;
        separator_seen <= separator_seen_next;
        failed         <= failed_next;
        digit_seen     <= digit_seen_next;
        if (comp_write) begin
          components[phase] <= comp_value_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && closes) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && closes) begin
      result <= result_next;
    end
  end

endmodule

FILE: design/dtp_checker.sv
// port-level checks for the timestamp text parser, bound to the top level
// depends on dtp_pkg and datetime_text_parser_macros.svh
`include "datetime_text_parser_macros.svh"

module dtp_checker
  import dtp_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  logic no_fields;
  logic no_time;
  logic no_date;
  logic held;
  logic fail_kind;
  logic time_kind;
  logic date_kind;
  logic empty_take;

  assign no_date   = (result.year_value == 32'd0) && (result.month_value == 32'd0)
                  && (result.day_value == 32'd0);
  assign no_time   = (result.hour_value == 32'd0) && (result.minute_value == 32'd0)
                  && (result.second_value == 32'd0);
  assign no_fields = no_date && no_time && (result.fraction_value == 32'd0);

  // conditions watched below
  assign held       = result_valid && !result_ready;
  assign fail_kind  = result_valid
                   && (result.result_kind == KIND_NONE || result.result_kind == KIND_ERROR);
  assign time_kind  = result_valid && (result.result_kind == KIND_TIME);
  assign date_kind  = result_valid && (result.result_kind == KIND_DATE);
  assign empty_take = item_valid && item_ready && item.empty_string && result_ready;

  // a waiting result holds until taken
  `DTP_ASSERT_NEXT(a_result_held, clk, rst, held, result_valid && $stable(result))

  // none and error carry no components
  `DTP_ASSERT_NOW(a_fail_zero, clk, rst, fail_kind, no_fields)

  // a time carries no date and no fraction
  `DTP_ASSERT_NOW(a_time_only, clk, rst, time_kind, no_date && result.fraction_value == 32'd0)

  // a date carries no time part
  `DTP_ASSERT_NOW(a_date_only, clk, rst, date_kind, no_time && result.fraction_value == 32'd0)

  // an empty-string request closes at once, so it passes through the input register into the result register
  `DTP_ASSERT_NOW(a_empty_closes, clk, rst, empty_take && !$past(result_valid), ##2 result_valid)

endmodule

bind datetime_text_parser dtp_checker u_dtp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: dv/datetime_text_parser_check.sv
// checker of the timestamp text parser: watches both channels, predicts, compares
// depends on dtp_pkg for the request and result types, the codes and the characters
module datetime_text_parser_check
  import dtp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      failures,
  output int      outstanding
);

  // parse state of the string in flight
  logic [2:0]  parse_phase;
  logic        colon_form;
  logic        separator_seen;
  logic        parse_failed;
  logic        digit_seen;
  logic [31:0] component [NUM_COMPONENTS];

  result_t awaited_results [$];
  result_t want;
  int      fail_count = 0;
  int      waiting    = 0;

  assign failures    = fail_count;
  assign outstanding = waiting;

  task automatic clear_parse();
    int k;
    parse_phase    = PH_FIRST;
    colon_form     = 1'b0;
    separator_seen = 1'b0;
    parse_failed   = 1'b0;
    digit_seen     = 1'b0;
    for (k = 0; k < NUM_COMPONENTS; k++) component[k] = '0;
  endtask

  // one character into the running parse
  task automatic parse_char(input logic [7:0] c);
    logic [2:0]  slot;
    logic [35:0] acc;
    logic        accepted;
    if (c == CH_COLON || c == CH_DASH) separator_seen = 1'b1;
    if (!parse_failed) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        slot = (parse_phase < NUM_COMPONENTS) ? parse_phase : PH_FRACTION;
        acc  = {4'd0, component[slot]} * 36'd10 + 36'(c - CH_ZERO);
        if (acc[35:32] != 4'd0) begin
          parse_failed = 1'b1;
        end else begin
          component[slot] = acc[31:0];
          digit_seen      = 1'b1;
        end
      end else if (!digit_seen) begin
        parse_failed = 1'b1;
      end else begin
        // which separator may close the current component
        accepted = 1'b0;
        case (parse_phase)
          PH_FIRST: begin
            if (c == CH_COLON) begin
              colon_form = 1'b1;
              accepted   = 1'b1;
            end else if (c == CH_DASH) begin
              colon_form = 1'b0;
              accepted   = 1'b1;
            end
          end
          PH_SECOND:           accepted = (c == (colon_form ? CH_COLON : CH_DASH));
          PH_THIRD:            accepted = !colon_form && c == CH_SPACE;
          PH_HOUR, PH_MINUTE:  accepted = (c == CH_COLON);
          PH_SEC:              accepted = (c == CH_DOT);
          default:             accepted = 1'b0;
        endcase
        if (accepted) begin
          parse_phase = parse_phase + 3'd1;
          digit_seen  = 1'b0;
        end else begin
          parse_failed = 1'b1;
        end
      end
    end
  endtask

  // the string closes: work out its result and start afresh
  task automatic close_string(input logic empty);
    result_t r;
    r = '0;
    if (empty || !separator_seen)
      r.result_kind = KIND_NONE;
    else if (parse_failed || !digit_seen)
      r.result_kind = KIND_ERROR;
    else if (parse_phase == PH_THIRD)
      r.result_kind = colon_form ? KIND_TIME : KIND_DATE;
    else if (parse_phase == PH_SEC || parse_phase == PH_FRACTION)
      r.result_kind = KIND_DATETIME;
    else
      r.result_kind = KIND_ERROR;

    if (r.result_kind == KIND_DATE || r.result_kind == KIND_DATETIME) begin
      r.year_value  = component[PH_FIRST];
      r.month_value = component[PH_SECOND];
      r.day_value   = component[PH_THIRD];
    end
    if (r.result_kind == KIND_TIME) begin
      r.hour_value   = component[PH_FIRST];
      r.minute_value = component[PH_SECOND];
      r.second_value = component[PH_THIRD];
    end
    if (r.result_kind == KIND_DATETIME) begin
      r.hour_value     = component[PH_HOUR];
      r.minute_value   = component[PH_MINUTE];
      r.second_value   = component[PH_SEC];
      r.fraction_value = (parse_phase == PH_FRACTION) ? component[PH_FRACTION] : '0;
    end
    awaited_results.push_back(r);
    clear_parse();
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fail_count++;
    end
  endtask

  // results are compared before the request of the same edge is taken in
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      awaited_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result_kind: expected no result, got %0d", result.result_kind);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(result.result_kind));
          check_field("year_value", want.year_value, result.year_value);
          check_field("month_value", want.month_value, result.month_value);
          check_field("day_value", want.day_value, result.day_value);
          check_field("hour_value", want.hour_value, result.hour_value);
          check_field("minute_value", want.minute_value, result.minute_value);
          check_field("second_value", want.second_value, result.second_value);
          check_field("fraction_value", want.fraction_value, result.fraction_value);
        end
      end
      if (item_valid && item_ready) begin
        if (!item.empty_string) parse_char(item.char_byte);
        if (item.empty_string || item.last_char) close_string(item.empty_string);
      end
    end
    waiting = awaited_results.size();
  end

endmodule

FILE: dv/datetime_text_parser_test.sv
// top of the timestamp parser testbench: clock, reset, request stimulus, verdict
// depends on dtp_pkg, the parser top level and datetime_text_parser_check
module datetime_text_parser_test
  import dtp_pkg::*;
();

  typedef logic [7:0] text_q_t [$];

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  int      failures;
  int      outstanding;

  int burst_left = 0;
  int chars_sent = 0;
  int ready_mode = 0;
  int ready_left = 0;

  datetime_text_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  datetime_text_parser_check i_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: windows of steady, random, mostly stalled or toggling ready
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      ready_left = 0;
    end else begin
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_left = $urandom_range(8, 64);
      end
      ready_left--;
      case (ready_mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= 1'($urandom_range(0, 1));
        2:       result_ready <= ($urandom_range(0, 7) == 0);
        default: result_ready <= ready_left[1];
      endcase
    end
  end

  // sender: bursts of random length, random gaps between them
  task automatic send_item(input item_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item       <= req;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (!req.empty_string) chars_sent++;
  endtask

  task automatic send_text(input text_q_t chars, input bit close);
    item_t req;
    int    i;
    for (i = 0; i < chars.size(); i++) begin
      req.char_byte    = chars[i];
      req.last_char    = close && (i == chars.size() - 1);
      req.empty_string = 1'b0;
      send_item(req);
    end
  endtask

  // null or empty string; character and last flag carry noise
  task automatic send_empty();
    item_t req;
    req.char_byte    = 8'($urandom_range(0, 255));
    req.last_char    = 1'($urandom_range(0, 1));
    req.empty_string = 1'b1;
    send_item(req);
  endtask

  function automatic text_q_t to_text(input string s);
    text_q_t chars;
    int      i;
    for (i = 0; i < s.len(); i++) chars.push_back(s[i]);
    return chars;
  endfunction

  // component digits: mostly short, sometimes at or past 32 bits
  function automatic string make_number();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:        return "4294967295";
      1:        return "4294967296";
      2:        return $sformatf("%0d", wide);
      3:        return $sformatf("%0d", $urandom);
      4:        return $sformatf("00%0d", $urandom_range(0, 99));
      5, 6, 7:  return $sformatf("%0d", $urandom_range(0, 9999));
      default:  return $sformatf("%0d", $urandom_range(0, 99));
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0:       return CH_COLON;
      1:       return CH_DASH;
      2:       return CH_SPACE;
      3:       return CH_DOT;
      4:       return CH_ZERO + 8'($urandom_range(0, 9));
      5, 6:    return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // mostly well-formed timestamps, some damaged, some pure noise
  function automatic text_q_t random_text();
    text_q_t     chars;
    string       s;
    int          form;
    int          len;
    int          at;
    logic [7:0]  c;
    form = $urandom_range(0, 9);
    if (form >= 8) begin
      len = $urandom_range(1, 12);
      repeat (len) begin
        c = noise_char();
        // the no-separator form must stay free of ':' and '-'
        if (form == 8 && (c == CH_COLON || c == CH_DASH)) c = CH_SPACE;
        chars.push_back(c);
      end
    end else begin
      if (form <= 1)
        s = $sformatf("%s:%s:%s", make_number(), make_number(), make_number());
      else
        s = $sformatf("%s-%s-%s", make_number(), make_number(), make_number());
      if (form >= 4)
        s = $sformatf("%s %s:%s:%s", s, make_number(), make_number(), make_number());
      if (form >= 6)
        s = $sformatf("%s.%s", s, make_number());
      chars = to_text(s);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          at = $urandom_range(0, chars.size() - 1);
          case ($urandom_range(0, 3))
            0:       chars[at] = noise_char();
            1:       chars.insert(at, noise_char());
            2:       if (chars.size() > 1) chars.delete(at);
            default: chars.push_back(noise_char());
          endcase
        end
      end
    end
    return chars;
  endfunction

  initial begin
    string   directed [$];
    text_q_t chars;
    int      i;
    int      pick;

    directed = '{
      "12:34:56", "2024-02-29", "1999-12-31 23:59:59", "2000-01-01 00:00:00.123456",
      "1-2-3 4:5:6", "0:0:0",
      "4294967295-4294967295-4294967295 4294967295:4294967295:4294967295.4294967295",
      "4294967296:1:1", "12345678901-1-1", "hello", "", "1::2", "12:34", "1-2",
      "1:2-3", "1:2:3 4", "1-2-3 4:5:6.7x", "1-2-3 4:5:6.7.8", "1-2-3 4:5:6.",
      "x1-2-3", "abc def", "1-2-3 ", "1-2-3T4:5:6", ":"
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed strings
    for (i = 0; i < directed.size(); i++) begin
      if (directed[i].len() == 0) send_empty();
      else send_text(to_text(directed[i]), 1'b1);
    end
    // empty flag in the middle of a string drops the partial text
    send_text(to_text("12:3"), 1'b0);
    send_empty();

    // random strings
    while (chars_sent < 700) begin
      chars = random_text();
      pick  = $urandom_range(0, 19);
      if (pick == 0) begin
        send_empty();
      end else if (pick == 1) begin
        send_text(chars, 1'b0);
        send_empty();
      end else begin
        send_text(chars, 1'b1);
      end
    end
    item_valid <= 1'b0;

    // drain, then allow for the pipeline before the verdict
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0)
      $display("datetime_text_parser: match");
    else
      $display("datetime_text_parser: mismatch");
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("datetime_text_parser: mismatch");
    $finish;
  end

endmodule

FILE: datetime_text_parser.f
+incdir+design
design/dtp_pkg.sv
design/datetime_text_parser.sv
design/dtp_checker.sv
dv/datetime_text_parser_check.sv
dv/datetime_text_parser_test.sv
